// ----- design/sfd_pkg.sv -----
// Shared constants for the serial frame deframer.
// No dependencies; used by sfd_payload_mem and serial_frame_deframer.
`default_nettype none

package sfd_pkg;

   // Byte and configuration widths
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 8;

   // Default largest payload held in the store
   localparam int MAX_PAYLOAD_DEF = 32;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_VALUE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_VALUE   = 8'd1;

   // Configuration reset values
   localparam logic [BYTE_W-1:0] START_VALUE_RST = 8'd170;
   localparam logic [BYTE_W-1:0] END_VALUE_RST   = 8'd85;

   // Result kinds
   localparam logic KIND_NACK = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

endpackage : sfd_pkg

`default_nettype wire

// ----- design/serial_frame_deframer.sv -----
// Serial frame deframer top level: frame phase tracking, result register, readout.
// Depends on sfd_pkg and sfd_payload_mem.
//
// Usage:
//   req_ channel carries one received byte per transaction. Frames are three
//   start bytes, a length byte, the payload and two end bytes.
//   rsp_ channel carries results: a single NACK (kind 0, last 1) on a framing
//   error, or a run of ACK results, one per payload byte, the last one marked.
//   csr_ channel writes start_value (index 0) and end_value (index 1); it is
//   always ready and other indexes are ignored.
// Timing:
//   A byte that gives no result or a NACK leaves byte intake running; a NACK is
//   visible on rsp_ the cycle after the byte is taken. The final end byte starts
//   a readout of the payload store, each payload byte by a store read, then a load
//   of the result register once it has room; no byte is taken during the readout.
//   A single result register separates the two sides; req_ready drops while it
//   is full and not being taken, so a stalled receiver holds back the sender.
// Reset:
//   Synchronous, active high. The phase returns to hunting for the first start
//   byte, counts clear and the configuration returns to 170 and 85. The payload
//   store needs no clearing: only bytes written in the current frame are read.
`default_nettype none

module serial_frame_deframer #(
   parameter int MAX_PAYLOAD = sfd_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Received bytes
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sfd_pkg::BYTE_W-1:0]    req_rx_byte,
   // Results
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_kind,
   output logic      [sfd_pkg::BYTE_W-1:0]    rsp_payload_byte,
   output logic                               rsp_byte_valid,
   output logic                               rsp_last,
   // Configuration
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sfd_pkg::BYTE_W-1:0]    csr_wdata
);

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1);
   localparam logic [sfd_pkg::BYTE_W-1:0] MAX_BYTE = sfd_pkg::BYTE_W'(MAX_PAYLOAD);
   localparam logic [CNT_W-1:0]           MAX_CNT  = CNT_W'(MAX_PAYLOAD);

   // Frame phases
   localparam logic [2:0] PH_START1 = 3'd0;
   localparam logic [2:0] PH_START2 = 3'd1;
   localparam logic [2:0] PH_START3 = 3'd2;
   localparam logic [2:0] PH_LEN    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_END1   = 3'd5;
   localparam logic [2:0] PH_END2   = 3'd6;

   // Control states
   localparam logic [1:0] CTL_RUN  = 2'd0;
   localparam logic [1:0] CTL_READ = 2'd1;
   localparam logic [1:0] CTL_LOAD = 2'd2;

   logic [sfd_pkg::BYTE_W-1:0] start_value_ff, start_value_in;
   logic [sfd_pkg::BYTE_W-1:0] end_value_ff, end_value_in;
   logic [2:0]                 phase_ff, phase_in;
   logic [CNT_W-1:0]           exp_len_ff, exp_len_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           rd_idx_ff, rd_idx_in;
   logic [1:0]                 ctl_ff, ctl_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [sfd_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                       rsp_bvalid_ff, rsp_bvalid_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       slot_free;
   logic                       req_fire;
   logic                       is_start;
   logic                       is_end;
   logic [CNT_W-1:0]           count_inc;
   logic                       mem_wr_en;
   logic                       mem_rd_en;
   logic [sfd_pkg::BYTE_W-1:0] mem_rd_data;
   logic                       rd_last;

   // Configuration port is always ready
   assign csr_ready = 1'b1;

   always_comb begin
      start_value_in = start_value_ff;
      end_value_in   = end_value_ff;
      if (csr_valid) begin
         if (csr_index == sfd_pkg::CSR_START_VALUE) begin
            start_value_in = csr_wdata;
         end else if (csr_index == sfd_pkg::CSR_END_VALUE) begin
            end_value_in = csr_wdata;
         end
      end
   end

   // Handshake and byte decode; a start match takes priority over an end match
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (ctl_ff == CTL_RUN) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign is_start  = (req_rx_byte == start_value_ff);
   assign is_end    = !is_start && (req_rx_byte == end_value_ff);
   assign count_inc = (count_ff < MAX_CNT) ? count_ff + CNT_W'(1) : count_ff;
   assign rd_last   = ((rd_idx_ff + CNT_W'(1)) == count_ff);

   // Frame phase tracking, readout sequencing and result register
   always_comb begin
      phase_in      = phase_ff;
      exp_len_in    = exp_len_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      ctl_in        = ctl_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bvalid_in = rsp_bvalid_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (ctl_ff)
         CTL_RUN: begin
            if (req_fire) begin
               // Default to a NACK; arms that give no result clear it
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = sfd_pkg::KIND_NACK;
               rsp_byte_in   = '0;
               rsp_bvalid_in = 1'b0;
               rsp_last_in   = 1'b1;
               unique case (phase_ff)
                  PH_START2, PH_START3: begin
                     if (is_start) begin
                        phase_in     = phase_ff + 3'd1;
                        count_in     = '0;
                        rsp_valid_in = 1'b0;
                     end else begin
                        phase_in = PH_START1;
                     end
                  end
                  PH_LEN: begin
                     if (is_start) begin
                        phase_in     = PH_START1;
                        count_in     = '0;
                        rsp_valid_in = 1'b0;
                     end else if (is_end || (req_rx_byte > MAX_BYTE)) begin
                        phase_in = PH_START1;
                     end else begin
                        exp_len_in   = CNT_W'(req_rx_byte);
                        phase_in     = PH_DATA;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  PH_DATA: begin
                     if (is_start) begin
                        count_in = '0;
                     end else if (is_end) begin
                        phase_in = PH_START1;
                     end else begin
                        mem_wr_en    = (count_ff < MAX_CNT);
                        count_in     = count_inc;
                        rsp_valid_in = 1'b0;
                        if (count_inc >= exp_len_ff || count_inc >= MAX_CNT) begin
                           phase_in = PH_END1;
                        end
                     end
                  end
                  PH_END1: begin
                     if (is_end) begin
                        phase_in     = PH_END2;
                        rsp_valid_in = 1'b0;
                     end else begin
                        phase_in = PH_START1;
                     end
                  end
                  PH_END2: begin
                     phase_in = PH_START1;
                     if (is_end) begin
                        // Start the payload readout
                        rsp_valid_in = 1'b0;
                        rd_idx_in    = '0;
                        ctl_in       = CTL_READ;
                     end
                  end
                  default: begin
                     if (is_start) begin
                        phase_in     = PH_START2;
                        count_in     = '0;
                        rsp_valid_in = 1'b0;
                     end else begin
                        phase_in = PH_START1;
                     end
                  end
               endcase
            end
         end
         CTL_READ: begin
            // Issue the store read for the next payload byte
            mem_rd_en = 1'b1;
            ctl_in    = CTL_LOAD;
         end
         CTL_LOAD: begin
            // Load the ACK once the result register has room
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = sfd_pkg::KIND_ACK;
               rsp_byte_in   = mem_rd_data;
               rsp_bvalid_in = 1'b1;
               rsp_last_in   = rd_last;
               if (rd_last) begin
                  ctl_in = CTL_RUN;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  ctl_in    = CTL_READ;
               end
            end
         end
         default: begin
            ctl_in = CTL_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff <= sfd_pkg::START_VALUE_RST;
         end_value_ff   <= sfd_pkg::END_VALUE_RST;
         phase_ff       <= PH_START1;
         exp_len_ff     <= '0;
         count_ff       <= '0;
         rd_idx_ff      <= '0;
         ctl_ff         <= CTL_RUN;
         rsp_valid_ff   <= 1'b0;
      end else begin
         start_value_ff <= start_value_in;
         end_value_ff   <= end_value_in;
         phase_ff       <= phase_in;
         exp_len_ff     <= exp_len_in;
         count_ff       <= count_in;
         rd_idx_ff      <= rd_idx_in;
         ctl_ff         <= ctl_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_bvalid_ff <= rsp_bvalid_in;
      rsp_last_ff   <= rsp_last_in;
   end

   sfd_payload_mem #(
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_payload_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx_ff[ADDR_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_byte_valid   = rsp_bvalid_ff;
   assign rsp_last         = rsp_last_ff;

endmodule : serial_frame_deframer

`default_nettype wire

// ----- design/sfd_payload_mem.sv -----
// Payload store: one write port, one read port, read data registered.
// Depends on sfd_pkg for the byte width.
`default_nettype none

module sfd_payload_mem #(
   parameter int DEPTH  = sfd_pkg::MAX_PAYLOAD_DEF,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [sfd_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                      rd_en,
   input  wire logic [ADDR_W-1:0]         rd_addr,
   output logic      [sfd_pkg::BYTE_W-1:0] rd_data
);

   logic [sfd_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [sfd_pkg::BYTE_W-1:0] rd_data_ff;

   // Write the incoming payload byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; hold the data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : sfd_payload_mem

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for serial_frame_deframer: byte driver, result monitor,
// in-bench frame predictor. Depends on sfd_pkg and the deframer RTL.

module tb_top;

   localparam int MAX_PAYLOAD    = sfd_pkg::MAX_PAYLOAD_DEF;
   localparam int CLK_HALF       = 5;
   localparam int SETTLE_CYCLES  = 2 * MAX_PAYLOAD + 16;
   localparam int STALL_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 3000;

   // Index with no register behind it
   localparam logic [sfd_pkg::CSR_IDX_W-1:0] CSR_IDX_UNUSED = 8'hFF;

   typedef enum logic [2:0] {
      PH_START1 = 3'd0,
      PH_START2 = 3'd1,
      PH_START3 = 3'd2,
      PH_LENGTH = 3'd3,
      PH_DATA   = 3'd4,
      PH_END1   = 3'd5,
      PH_END2   = 3'd6
   } frame_phase_type;

   typedef struct packed {
      logic                       kind;
      logic [sfd_pkg::BYTE_W-1:0] data;
      logic                       data_valid;
      logic                       last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          req_valid   = 1'b0;
   logic                          req_ready;
   logic [sfd_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_ready   = 1'b0;
   logic                          rsp_kind;
   logic [sfd_pkg::BYTE_W-1:0]    rsp_payload_byte;
   logic                          rsp_byte_valid;
   logic                          rsp_last;
   logic                          csr_valid   = 1'b0;
   logic                          csr_ready;
   logic [sfd_pkg::CSR_IDX_W-1:0] csr_index   = '0;
   logic [sfd_pkg::BYTE_W-1:0]    csr_wdata   = '0;

   // Stimulus and scoreboard state
   logic [sfd_pkg::BYTE_W-1:0] rx_bytes_pending[$];
   frame_result_type           expected_results[$];
   int                         send_idle_pct   = 0;
   int                         recv_idle_pct   = 0;
   int                         mismatch_count  = 0;
   int                         hold_left       = 0;
   logic                       stall_armed     = 1'b0;
   logic                       stall_done      = 1'b0;
   int                         quiet_cycles    = 0;

   // Predictor state
   logic [sfd_pkg::BYTE_W-1:0] cfg_start   = sfd_pkg::START_VALUE_RST;
   logic [sfd_pkg::BYTE_W-1:0] cfg_end     = sfd_pkg::END_VALUE_RST;
   frame_phase_type            frame_phase = PH_START1;
   int                         frame_len   = 0;
   int                         data_count  = 0;
   logic [sfd_pkg::BYTE_W-1:0] payload_buf[MAX_PAYLOAD];

   serial_frame_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   task report_mismatch(input string what, input int got, input int want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function void expect_result(input logic kind, input logic [sfd_pkg::BYTE_W-1:0] data,
                               input logic data_valid, input logic last);
      frame_result_type r;
      r.kind       = kind;
      r.data       = data;
      r.data_valid = data_valid;
      r.last       = last;
      expected_results.push_back(r);
   endfunction

   // Single NACK, then hunt for a fresh start
   function void expect_nack_and_hunt();
      expect_result(sfd_pkg::KIND_NACK, '0, 1'b0, 1'b1);
      frame_phase = PH_START1;
   endfunction

   // Advance the frame predictor by one received byte
   function void deframe_byte(input logic [sfd_pkg::BYTE_W-1:0] rx);
      logic is_start;
      logic is_end;
      is_start = (rx == cfg_start);
      is_end   = !is_start && (rx == cfg_end);
      case (frame_phase)
         PH_START2, PH_START3: begin
            if (is_start) begin
               frame_phase = (frame_phase == PH_START2) ? PH_START3 : PH_LENGTH;
               data_count  = 0;
            end else begin
               expect_nack_and_hunt();
            end
         end
         PH_LENGTH: begin
            // a start here drops back silently
            if (is_start) begin
               frame_phase = PH_START1;
               data_count  = 0;
            end else if (is_end || int'(rx) > MAX_PAYLOAD) begin
               expect_nack_and_hunt();
            end else begin
               frame_len   = int'(rx);
               frame_phase = PH_DATA;
            end
         end
         PH_DATA: begin
            if (is_start) begin
               // restart the count but stay in the payload
               data_count = 0;
               expect_result(sfd_pkg::KIND_NACK, '0, 1'b0, 1'b1);
            end else if (is_end) begin
               expect_nack_and_hunt();
            end else begin
               if (data_count < MAX_PAYLOAD) begin
                  payload_buf[data_count] = rx;
                  data_count++;
               end
               // zero length still takes one byte
               if (data_count >= frame_len || data_count >= MAX_PAYLOAD)
                  frame_phase = PH_END1;
            end
         end
         PH_END1: begin
            if (is_end) frame_phase = PH_END2;
            else        expect_nack_and_hunt();
         end
         PH_END2: begin
            if (is_end) begin
               frame_phase = PH_START1;
               for (int i = 0; i < data_count; i++)
                  expect_result(sfd_pkg::KIND_ACK, payload_buf[i], 1'b1,
                                (i + 1 == data_count));
            end else begin
               expect_nack_and_hunt();
            end
         end
         default: begin
            if (is_start) begin
               frame_phase = PH_START2;
               data_count  = 0;
            end else begin
               expect_nack_and_hunt();
            end
         end
      endcase
   endfunction

   // Driver: offer queued bytes, hold each until taken
   always @(posedge clock) begin : rx_driver
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
         if (!(req_valid && !req_ready)) begin
            offer = (rx_bytes_pending.size() != 0) &&
                    ($urandom_range(99) >= send_idle_pct);
            if (offer) begin
               req_valid   <= 1'b1;
               req_rx_byte <= rx_bytes_pending.pop_front();
            end else begin
               req_valid   <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, once, when armed
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (stall_armed && !stall_done) begin
         hold_left  <= STALL_CYCLES;
         stall_done <= 1'b1;
      end
   end

   // Monitor: take results and compare with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      frame_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_payload_byte, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind != want.kind)
                  report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_payload_byte != want.data)
                  report_mismatch("payload_byte", rsp_payload_byte, want.data);
               if (rsp_byte_valid != want.data_valid)
                  report_mismatch("byte_valid", rsp_byte_valid, want.data_valid);
               if (rsp_last != want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: end the run if no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Call at a rising edge; returns at a rising edge with valid lowered
   task write_csr(input logic [sfd_pkg::CSR_IDX_W-1:0] idx,
                  input logic [sfd_pkg::BYTE_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == sfd_pkg::CSR_START_VALUE)    cfg_start = data;
      else if (idx == sfd_pkg::CSR_END_VALUE) cfg_end   = data;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every byte is taken and every result is in, then let it settle
   task wait_idle();
      do @(negedge clock);
      while (rx_bytes_pending.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [sfd_pkg::BYTE_W-1:0] pick_payload(input logic raw);
      logic [sfd_pkg::BYTE_W-1:0] b;
      b = sfd_pkg::BYTE_W'($urandom_range(255));
      while (!raw && (b == cfg_start || b == cfg_end))
         b = sfd_pkg::BYTE_W'($urandom_range(255));
      return b;
   endfunction

   // Mostly well-formed frames with random content, some broken, some noise
   task automatic queue_random_traffic(input int n_bytes);
      logic [sfd_pkg::BYTE_W-1:0] frame[$];
      int   len;
      int   n_data;
      int   pick;
      int   added;
      logic raw;
      added = 0;
      while (added < n_bytes) begin
         frame.delete();
         if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 4))
               frame.push_back(sfd_pkg::BYTE_W'($urandom_range(255)));
         end else begin
            pick = $urandom_range(99);
            if (pick < 65)      len = $urandom_range(0, 6);
            else if (pick < 85) len = $urandom_range(7, MAX_PAYLOAD);
            else if (pick < 93) len = MAX_PAYLOAD;
            else                len = $urandom_range(MAX_PAYLOAD + 1, 255);
            raw = ($urandom_range(99) < 10);
            repeat (3) frame.push_back(cfg_start);
            frame.push_back(len[sfd_pkg::BYTE_W-1:0]);
            if (len > MAX_PAYLOAD) n_data = $urandom_range(0, 2);
            else if (len == 0)     n_data = 1;
            else                   n_data = len;
            repeat (n_data) frame.push_back(pick_payload(raw));
            repeat (2) frame.push_back(cfg_end);
            // corrupt one byte or cut the frame short
            pick = $urandom_range(99);
            if (pick < 12)
               frame[$urandom_range(frame.size() - 1)] =
                  sfd_pkg::BYTE_W'($urandom_range(255));
            else if (pick < 20)
               repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
         end
         foreach (frame[i]) rx_bytes_pending.push_back(frame[i]);
         added += frame.size();
      end
   endtask

   initial begin : stimulus
      logic [sfd_pkg::BYTE_W-1:0] directed[$];
      logic [sfd_pkg::BYTE_W-1:0] v;
      logic [sfd_pkg::BYTE_W-1:0] sv;
      logic [sfd_pkg::BYTE_W-1:0] ev;
      sv = sfd_pkg::START_VALUE_RST;
      ev = sfd_pkg::END_VALUE_RST;
      directed = {8'h00,
                  sv, sv, sv, sv,
                  sv, sv, sv, ev,
                  sv, sv, sv, 8'hFF,
                  sv, sv, sv, 8'h00, 8'h00,
                  ev, ev,
                  sv, sv, sv, 8'h02,
                  sv, ev};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default markers; sender idles lightly, receiver heavily
      write_csr(sfd_pkg::CSR_START_VALUE, sfd_pkg::START_VALUE_RST);
      write_csr(sfd_pkg::CSR_END_VALUE, sfd_pkg::END_VALUE_RST);
      @(negedge clock);
      send_idle_pct = 21;
      recv_idle_pct = 65;
      foreach (directed[i]) rx_bytes_pending.push_back(directed[i]);
      queue_random_traffic(115);
      wait_idle();

      // Extreme markers; idling swapped
      write_csr(sfd_pkg::CSR_START_VALUE, 8'h00);
      write_csr(sfd_pkg::CSR_END_VALUE, 8'hFF);
      @(negedge clock);
      send_idle_pct = 65;
      recv_idle_pct = 21;
      queue_random_traffic(115);
      wait_idle();

      // Extremes reversed; no idling, one long receiver hold-off
      write_csr(sfd_pkg::CSR_START_VALUE, 8'hFF);
      write_csr(sfd_pkg::CSR_END_VALUE, 8'h00);
      @(negedge clock);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_traffic(100);
      stall_armed = 1'b1;
      wait_idle();

      // Equal markers: every such byte decodes as a start; unused index ignored
      v = sfd_pkg::BYTE_W'($urandom_range(255));
      write_csr(sfd_pkg::CSR_START_VALUE, v);
      write_csr(sfd_pkg::CSR_END_VALUE, v);
      write_csr(CSR_IDX_UNUSED, sfd_pkg::BYTE_W'($urandom_range(255)));
      @(negedge clock);
      queue_random_traffic(55);
      wait_idle();

      // Random distinct markers
      v = sfd_pkg::BYTE_W'($urandom_range(255));
      write_csr(sfd_pkg::CSR_START_VALUE, v);
      write_csr(sfd_pkg::CSR_END_VALUE, v ^ 8'(1 << $urandom_range(7)));
      @(negedge clock);
      queue_random_traffic(60);
      wait_idle();

      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- serial_frame_deframer.f -----
design/sfd_pkg.sv
design/sfd_payload_mem.sv
design/serial_frame_deframer.sv
tb/tb_top.sv
